// File: rtl/track_initiation_fsm_macros.svh
// assertion macros for the track initiation block
// clocked on clk_i; TIF_ASSERT is disabled by rst_ni in the including module
`ifndef TRACK_INITIATION_FSM_MACROS_SVH
`define TRACK_INITIATION_FSM_MACROS_SVH
`ifndef SYNTHESIS
`define TIF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("track initiation check failed");
`define TIF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("track initiation check failed");
`else
`define TIF_ASSERT(label, prop)
`define TIF_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/tif_pkg.sv
// types and constants of the track initiation block
// no dependencies
`default_nettype none
package tif_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned LimitW  = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned NumberW = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IdW     = 17;
  localparam int unsigned IndexW  = 2;
  localparam int unsigned DataW   = 32;

  localparam logic [LimitW-1:0]  LimitReset   = 32'd45000;
  localparam logic [CountW-1:0]  ConfirmReset = 4'd3;
  localparam logic [NumberW-1:0] NumberReset  = 16'd1001;
  localparam logic [CountW-1:0]  CountMax     = 4'd15;
  localparam logic signed [IdW-1:0] IdNone    = -17'sd1;

  typedef enum logic [1:0] {
    TRK_FREE      = 2'd0,
    TRK_INIT      = 2'd1,
    TRK_CONFIRMED = 2'd2,
    TRK_COASTING  = 2'd3
  } trk_state_e;

  typedef enum logic [StatusW-1:0] {
    STS_FREE      = 3'd0,
    STS_INIT      = 3'd1,
    STS_CONFIRMED = 3'd2,
    STS_COASTING  = 3'd3,
    STS_RESTORED  = 3'd4
  } status_e;

  typedef enum logic [IndexW-1:0] {
    REG_LIFETIME = 2'd0,
    REG_CONFIRM  = 2'd1,
    REG_TRACKNUM = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LimitW-1:0]  lifetime_limit;
    logic [CountW-1:0]  confirm_hits;
    logic [NumberW-1:0] track_number;
  } cfg_t;

  typedef struct packed {
    logic             vld;
    logic             hit_valid;
    logic [TimeW-1:0] time_ms;
  } stage_t;

endpackage
`default_nettype wire

// File: rtl/tif_ifs.sv
// handshake channels of the track initiation block: input, result, config
// depends on tif_pkg
`default_nettype none
interface tif_in_if;
  import tif_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit_valid;
  logic [TimeW-1:0] time_ms;
  modport source (output valid, output hit_valid, output time_ms, input ready);
  modport sink (input valid, input hit_valid, input time_ms, output ready);
endinterface

interface tif_out_if;
  import tif_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [StatusW-1:0]    track_status;
  logic signed [IdW-1:0] reported_id;
  modport source (output valid, output track_status, output reported_id, input ready);
  modport sink (input valid, input track_status, input reported_id, output ready);
endinterface

interface tif_cfg_if;
  import tif_pkg::*;
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] index;
  logic [DataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/tif_cfg_regs.sv
// configuration register file of the track initiation block
// depends on tif_pkg and tif_cfg_if
`default_nettype none
module tif_cfg_regs (
  input  wire         clk_i,
  input  wire         rst_ni,
  tif_cfg_if.sink     cfg_i,
  output tif_pkg::cfg_t cfg_o
);
  import tif_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_LIFETIME: cfg_d.lifetime_limit = cfg_i.data[LimitW-1:0];
        REG_CONFIRM:  cfg_d.confirm_hits   = cfg_i.data[CountW-1:0];
        REG_TRACKNUM: cfg_d.track_number   = cfg_i.data[NumberW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lifetime_limit <= LimitReset;
      cfg_q.confirm_hits   <= ConfirmReset;
      cfg_q.track_number   <= NumberReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/tif_in_stage.sv
// input register of the track initiation block
// depends on tif_pkg and tif_in_if
`default_nettype none
module tif_in_stage (
  input  wire            clk_i,
  input  wire            rst_ni,
  tif_in_if.sink         in_i,
  input  wire            adv_i,
  output tif_pkg::stage_t stg_o
);
  import tif_pkg::*;

  logic             vld_q;
  logic             hit_q;
  logic [TimeW-1:0] time_q;
  logic             load;

  assign load       = !vld_q || adv_i;
  assign in_i.ready = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_i.valid) begin
      hit_q  <= in_i.hit_valid;
      time_q <= in_i.time_ms;
    end
  end

  assign stg_o = {vld_q, hit_q, time_q};

endmodule
`default_nettype wire

// File: rtl/tif_core.sv
// track state machine and result register
// depends on tif_pkg and tif_out_if
`default_nettype none
module tif_core (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire tif_pkg::cfg_t   cfg_i,
  input  wire tif_pkg::stage_t stg_i,
  output logic           adv_o,
  tif_out_if.source      out_o
);
  import tif_pkg::*;

  trk_state_e           state_q, state_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic [TimeW-1:0]     last_q, last_d;
  logic                 out_vld_q;
  status_e              status_q, status_d;
  logic signed [IdW-1:0] id_q, id_d;

  logic [CountW-1:0] cnt_inc;
  logic [TimeW-1:0]  age;
  logic              expired;
  logic              fire;
  logic signed [IdW-1:0] id_track;

  assign adv_o    = !out_vld_q || out_o.ready;
  assign fire     = adv_o && stg_i.vld;
  assign cnt_inc  = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
  assign age      = stg_i.time_ms - last_q;
  assign expired  = age > cfg_i.lifetime_limit;
  assign id_track = $signed({1'b0, cfg_i.track_number});

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    unique case (state_q)
      TRK_FREE: begin
        if (stg_i.hit_valid) begin
          cnt_d   = cnt_inc;
          state_d = TRK_INIT;
        end
      end
      TRK_INIT: begin
        if (stg_i.hit_valid) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.confirm_hits) begin
            state_d = TRK_CONFIRMED;
            last_d  = stg_i.time_ms;
          end
        end else begin
          cnt_d   = '0;
          state_d = TRK_FREE;
        end
      end
      TRK_CONFIRMED: begin
        if (stg_i.hit_valid) begin
          last_d = stg_i.time_ms;
        end else begin
          state_d = TRK_COASTING;
        end
      end
      TRK_COASTING: begin
        if (stg_i.hit_valid) begin
          state_d = TRK_CONFIRMED;
        end else if (expired) begin
          state_d = TRK_FREE;
          cnt_d   = '0;
        end
      end
      default: state_d = TRK_FREE;
    endcase
  end

  // result
  always_comb begin
    status_d = STS_FREE;
    id_d     = IdNone;
    unique case (state_q)
      TRK_FREE: begin
        status_d = stg_i.hit_valid ? STS_INIT : STS_FREE;
        id_d     = IdNone;
      end
      TRK_INIT: begin
        status_d = status_e'({1'b0, state_d});
        id_d     = id_track;
      end
      TRK_CONFIRMED: begin
        status_d = stg_i.hit_valid ? STS_CONFIRMED : STS_COASTING;
        id_d     = id_track;
      end
      TRK_COASTING: begin
        if (stg_i.hit_valid) begin
          status_d = STS_RESTORED;
          id_d     = id_track;
        end else if (expired) begin
          status_d = STS_FREE;
          id_d     = IdNone;
        end else begin
          status_d = STS_COASTING;
          id_d     = id_track;
        end
      end
      default: begin
        status_d = STS_FREE;
        id_d     = IdNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TRK_FREE;
      cnt_q     <= '0;
      last_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_o) begin
        out_vld_q <= stg_i.vld;
      end
      if (fire) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
        last_q  <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      id_q     <= id_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.track_status = status_q;
  assign out_o.reported_id  = id_q;

endmodule
`default_nettype wire

// File: rtl/track_initiation_fsm.sv
// Single-track radar initiation / confirm / coast / delete block.
// Channels: in_i carries one radar interval per word (hit_valid, time_ms);
// out_o returns one word per interval (track_status, reported_id, -1 when
// no track exists); cfg_i writes lifetime_limit (0), confirm_hits (1) and
// track_number (2), other indexes are ignored; cfg_i is always ready.
// An accepted word is registered in the input stage; the state update and
// result are computed from it and registered in the result register.
// Words are taken at one per cycle while out_o accepts results; the state
// update lies combinationally between the input and result registers.
// Reset puts the track in free with a zero hit count and last hit time, and
// restores the configuration to 45000 ms, 3 hits and id 1001.
// When out_o stalls, the result register holds and the input stage still
// takes a word if it is empty; then in_i.ready drops until the result leaves.
// Depends on tif_pkg, tif_ifs and track_initiation_fsm_macros.svh.
`default_nettype none
`include "track_initiation_fsm_macros.svh"
module track_initiation_fsm (
  input  wire      clk_i,
  input  wire      rst_ni,
  tif_in_if.sink   in_i,
  tif_out_if.source out_o,
  tif_cfg_if.sink  cfg_i
);
  import tif_pkg::*;

  cfg_t   cfg;
  stage_t stg;
  logic   adv;

  tif_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tif_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .stg_o  (stg)
  );

  tif_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .stg_i  (stg),
    .adv_o  (adv),
    .out_o  (out_o)
  );

  `TIF_ASSERT(a_live_id, out_o.valid && out_o.track_status >= STS_CONFIRMED |-> !out_o.reported_id[IdW-1])
  `TIF_ASSERT(a_stage_held, (stg.vld && !adv) |=> stg.vld)
  `TIF_ASSERT(a_out_source, $rose(out_o.valid) |-> $past(stg.vld))

endmodule
`default_nettype wire

// File: test/track_initiation_fsm_test.sv
`timescale 1ns / 1ps
// testbench of track_initiation_fsm: drives radar intervals and register writes,
// predicts the status word of every interval and checks it on the result channel
// depends on tif_pkg, tif_ifs and track_initiation_fsm
module track_initiation_fsm_test;
  import tif_pkg::*;

  localparam logic [IndexW-1:0] RegUnused = 2'd3;
  localparam logic [LimitW-1:0] DroneLimit = 32'd30000;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainCycles = 4;

  typedef struct packed {
    logic [StatusW-1:0]    status;
    logic signed [IdW-1:0] id;
  } track_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tif_in_if  in_ch ();
  tif_out_if res_ch ();
  tif_cfg_if cfg_ch ();

  track_initiation_fsm dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always #6 clk_i = ~clk_i;

  // predicted registers and track state
  logic [LimitW-1:0]  lifetime_q;
  logic [CountW-1:0]  confirm_q;
  logic [NumberW-1:0] number_q;
  trk_state_e         track_q;
  logic [CountW-1:0]  hits_q;
  logic [TimeW-1:0]   last_hit_q;

  track_report_t    pending_reports[$];
  track_report_t    want_report;
  int               errors = 0;
  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      quiet_cycles = 0;
  logic [TimeW-1:0] now_ms;

  function automatic void reset_track_model();
    lifetime_q = LimitReset;
    confirm_q  = ConfirmReset;
    number_q   = NumberReset;
    track_q    = TRK_FREE;
    hits_q     = '0;
    last_hit_q = '0;
  endfunction

  function automatic track_report_t advance_track(input logic hit, input logic [TimeW-1:0] now);
    track_report_t         rpt;
    logic signed [IdW-1:0] own_id;
    logic [TimeW-1:0]      age;
    own_id = {1'b0, number_q};
    age = now - last_hit_q;
    rpt.status = STS_FREE;
    rpt.id = IdNone;
    case (track_q)
      TRK_FREE: begin
        if (hit) begin
          if (hits_q != CountMax) hits_q = hits_q + 1'b1;
          track_q = TRK_INIT;
          rpt.status = STS_INIT;
        end
      end
      TRK_INIT: begin
        rpt.id = own_id;
        if (hit) begin
          if (hits_q != CountMax) hits_q = hits_q + 1'b1;
          if (hits_q >= confirm_q) begin
            track_q = TRK_CONFIRMED;
            last_hit_q = now;
            rpt.status = STS_CONFIRMED;
          end else begin
            rpt.status = STS_INIT;
          end
        end else begin
          hits_q = '0;
          track_q = TRK_FREE;
        end
      end
      TRK_CONFIRMED: begin
        rpt.id = own_id;
        if (hit) begin
          last_hit_q = now;
          rpt.status = STS_CONFIRMED;
        end else begin
          track_q = TRK_COASTING;
          rpt.status = STS_COASTING;
        end
      end
      default: begin
        if (hit) begin
          track_q = TRK_CONFIRMED;
          rpt.status = STS_RESTORED;
          rpt.id = own_id;
        end else if (age > lifetime_q) begin
          track_q = TRK_FREE;
          hits_q = '0;
        end else begin
          rpt.status = STS_COASTING;
          rpt.id = own_id;
        end
      end
    endcase
    return rpt;
  endfunction

  // entered and left at a falling edge; valid stays high for a following word
  task automatic send_interval(input logic hit, input logic [TimeW-1:0] stamp);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.hit_valid = hit;
    in_ch.time_ms = stamp;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_reports.push_back(advance_track(hit, stamp));
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [DataW-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_LIFETIME: lifetime_q = value;
      REG_CONFIRM:  confirm_q = value[CountW-1:0];
      REG_TRACKNUM: number_q = value[NumberW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_for_quiet();
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic pick_config();
    logic [LimitW-1:0] limit;
    case ($urandom_range(9))
      0: limit = '0;
      1: limit = '1;
      2: limit = DroneLimit;
      3: limit = LimitReset;
      4: limit = $urandom;
      default: limit = $urandom_range(3000);
    endcase
    write_reg(REG_LIFETIME, limit);
    write_reg(REG_CONFIRM, $urandom);
    write_reg(REG_TRACKNUM, $urandom);
    if ($urandom_range(3) == 0) write_reg(RegUnused, $urandom);
  endtask

  task automatic run_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned next_cfg;
    int unsigned burst;
    int unsigned hit_pct;
    int unsigned step_max;
    logic        hit;
    sent = 0;
    next_cfg = 0;
    while (sent < count) begin
      if (sent >= next_cfg) begin
        wait_for_quiet();
        pick_config();
        now_ms = $urandom;
        next_cfg = sent + $urandom_range(40, 100);
      end
      burst = $urandom_range(3, 25);
      case ($urandom_range(3))
        0: hit_pct = 95;
        1: hit_pct = 70;
        2: hit_pct = 30;
        default: hit_pct = 5;
      endcase
      step_max = (lifetime_q < 65536) ? lifetime_q / 3 + 2 : 65536;
      for (int k = 0; k < burst && sent < count; k++) begin
        // occasional jump anywhere, also backward in time
        if ($urandom_range(19) == 0) now_ms = $urandom;
        else now_ms = now_ms + $urandom_range(step_max);
        hit = ($urandom_range(99) < hit_pct);
        send_interval(hit, now_ms);
        sent++;
      end
    end
  endtask

  task automatic test_default_lifecycle();
    send_interval(1'b0, 32'd0);
    send_interval(1'b1, 32'd100);
    send_interval(1'b0, 32'd200);
    send_interval(1'b1, 32'd0);
    send_interval(1'b1, 32'd500);
    send_interval(1'b1, 32'd1000);
    send_interval(1'b1, 32'd2000);
    send_interval(1'b0, 32'd30000);
    send_interval(1'b0, 32'd47000);
    send_interval(1'b1, 32'd50000);
    send_interval(1'b0, 32'd47000);
    send_interval(1'b0, 32'd47001);
    // timestamp behind the last hit looks like a huge age
    send_interval(1'b1, 32'd20);
    send_interval(1'b1, 32'd20);
    send_interval(1'b1, 32'd20);
    send_interval(1'b0, 32'd10);
    send_interval(1'b0, 32'd10);
    wait_for_quiet();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_LIFETIME, 32'h0000_0000);
    write_reg(REG_CONFIRM, 32'hFFFF_FFF0);
    write_reg(REG_TRACKNUM, 32'hFFFF_0000);
    send_interval(1'b1, 32'd7);
    send_interval(1'b1, 32'd7);
    send_interval(1'b0, 32'd7);
    send_interval(1'b0, 32'd7);
    send_interval(1'b0, 32'd8);
    wait_for_quiet();
    write_reg(REG_LIFETIME, 32'hFFFF_FFFF);
    write_reg(REG_CONFIRM, 32'hABCD_0001);
    write_reg(REG_TRACKNUM, 32'h1234_FFFF);
    send_interval(1'b1, 32'hFFFF_FFFF);
    send_interval(1'b1, 32'h0000_0000);
    send_interval(1'b0, 32'hFFFF_FFFE);
    send_interval(1'b0, 32'hFFFF_FFFF);
    send_interval(1'b1, 32'h0000_0005);
    wait_for_quiet();
  endtask

  task automatic test_unlisted_index();
    write_reg(RegUnused, 32'h0000_0000);
    send_interval(1'b0, 32'h8000_0000);
    send_interval(1'b0, 32'h7FFF_FFFF);
    wait_for_quiet();
  endtask

  task automatic test_random_traffic();
    idle_pct = 0;
    stall_pct = 0;
    run_traffic(250);
    idle_pct = 82;
    stall_pct = 0;
    run_traffic(250);
    idle_pct = 0;
    stall_pct = 82;
    run_traffic(250);
    idle_pct = 21;
    stall_pct = 21;
    run_traffic(250);
    wait_for_quiet();
  endtask

  always @(negedge clk_i) begin
    res_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result word: track_status %0d reported_id %0d",
               res_ch.track_status, res_ch.reported_id);
        errors++;
      end else begin
        want_report = pending_reports.pop_front();
        if (res_ch.track_status !== want_report.status) begin
          $error("track_status: expected %0d, got %0d", want_report.status,
                 res_ch.track_status);
          errors++;
        end
        if (res_ch.reported_id !== want_report.id) begin
          $error("reported_id: expected %0d, got %0d", want_report.id, res_ch.reported_id);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("track_initiation_fsm_test failed");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.hit_valid = 1'b0;
    in_ch.time_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    now_ms = '0;
    reset_track_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_default_lifecycle();
    test_register_extremes();
    test_unlisted_index();
    test_random_traffic();
    if (errors == 0) begin
      $display("track_initiation_fsm_test passed");
    end else begin
      $display("track_initiation_fsm_test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tif_pkg.sv
rtl/tif_ifs.sv
rtl/tif_cfg_regs.sv
rtl/tif_in_stage.sv
rtl/tif_core.sv
rtl/track_initiation_fsm.sv
test/track_initiation_fsm_test.sv
